[design/ppp_async_frame_receive_defines.svh]
// ----------------------------------------------------------------------------
// PPP async frame receive assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PPP_ASYNC_FRAME_RECEIVE_DEFINES_SVH
`define PPP_ASYNC_FRAME_RECEIVE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PAFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PAFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ppp_afr_pkg.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive package
// Byte codes, status codes, register indexes, result types and FCS-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_afr_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7e;
    localparam logic [7:0]  ESC_BYTE  = 8'h7d;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_INIT  = 16'hffff;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_GOOD  = 16'hf0b8;

    localparam logic [1:0]  STATUS_GOOD    = 2'd0;
    localparam logic [1:0]  STATUS_FCS_ERR = 2'd1;
    localparam logic [1:0]  STATUS_BAD     = 2'd2;

    localparam int          CFG_INDEX_W    = 2;
    localparam logic [1:0]  CFG_RX_MAP     = 2'd0;
    localparam logic [1:0]  CFG_MAX_LEN    = 2'd1;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd1500;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  data_byte;
        logic [1:0]  frame_status;
        logic [15:0] frame_length;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } core_res_t;

    // one byte of the reflected CRC-16, LSB first
    function automatic logic [15:0] fcs16_update(input logic [15:0] fcs,
                                                 input logic [7:0]  b);
        logic [15:0] v;
        v = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (v[0])
                v = (v >> 1) ^ FCS_POLY;
            else
                v = v >> 1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[design/ppp_afr_if.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive channel interfaces
// Line byte channel and deframed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppp_afr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ppp_afr_res_if;
    logic        valid;
    logic        ready;
    logic        is_end;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;

    modport source (output valid, output is_end, output data_byte,
                    output frame_status, output frame_length, input ready);
    modport sink   (input valid, input is_end, input data_byte,
                    input frame_status, input frame_length, output ready);
endinterface

`default_nettype wire

[design/ppp_afr_in_reg.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive input register
// Holds one accepted line byte until the deframer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_afr_in_reg
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ppp_afr_rx_if.sink      rx_in,
    input  wire logic       advance,
    output logic            s1_valid,
    output logic [7:0]      s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign rx_in.ready = !valid_reg || advance;
    assign s1_valid    = valid_reg;
    assign s1_byte     = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx_in.ready)
            valid_next = rx_in.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_in.valid && rx_in.ready)
            byte_reg <= rx_in.rx_byte;
    end

endmodule

`default_nettype wire

[design/ppp_afr_core.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive deframer core
// Frame state, unescape, control-map filter, length limit and FCS-16 check.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_afr_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [31:0]                  cfg_wdata,
    input  wire logic                         s1_valid,
    input  wire logic [7:0]                   s1_byte,
    input  wire logic                         advance,
    output ppp_afr_pkg::core_res_t            core_res
);

    import ppp_afr_pkg::*;

    logic [31:0] rx_map_reg;
    logic [15:0] max_len_reg;

    logic        in_frame_reg,  in_frame_next;
    logic        esc_reg,       esc_next;
    logic        bad_reg,       bad_next;
    logic [15:0] fcs_reg,       fcs_next;
    logic [15:0] count_reg,     count_next;

    // state as seen after a possible frame open
    logic        esc_eff;
    logic        bad_eff;
    logic [15:0] fcs_eff;
    logic [15:0] count_eff;
    logic [7:0]  ub;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        bad_next      = bad_reg;
        fcs_next      = fcs_reg;
        count_next    = count_reg;
        core_res      = '0;

        esc_eff   = in_frame_reg ? esc_reg   : 1'b0;
        bad_eff   = in_frame_reg ? bad_reg   : 1'b0;
        fcs_eff   = in_frame_reg ? fcs_reg   : FCS_INIT;
        count_eff = in_frame_reg ? count_reg : 16'd0;
        ub        = esc_eff ? (s1_byte ^ ESC_XOR) : s1_byte;

        if (s1_byte == FLAG_BYTE)
        begin
            if (in_frame_reg)
            begin
                core_res.valid            = 1'b1;
                core_res.res.is_end       = 1'b1;
                core_res.res.frame_length = count_reg;
                if (bad_reg || esc_reg)
                    core_res.res.frame_status = STATUS_BAD;
                else if (fcs_reg == FCS_GOOD)
                    core_res.res.frame_status = STATUS_GOOD;
                else
                    core_res.res.frame_status = STATUS_FCS_ERR;
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                bad_next      = bad_reg || esc_reg;
            end
        end
        else
        begin
            in_frame_next = 1'b1;
            esc_next      = esc_eff;
            bad_next      = bad_eff;
            fcs_next      = fcs_eff;
            count_next    = count_eff;
            if (!bad_eff)
            begin
                if (s1_byte == ESC_BYTE)
                    esc_next = 1'b1;
                else if (!(s1_byte < 8'h20 && rx_map_reg[s1_byte[4:0]]))
                begin
                    esc_next = 1'b0;
                    if (count_eff >= max_len_reg)
                        bad_next = 1'b1;
                    else
                    begin
                        count_next              = count_eff + 16'd1;
                        fcs_next                = fcs16_update(fcs_eff, ub);
                        core_res.valid          = 1'b1;
                        core_res.res.data_byte  = ub;
                    end
                end
            end
        end

        if (!s1_valid)
            core_res.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            bad_reg      <= 1'b0;
            fcs_reg      <= FCS_INIT;
            count_reg    <= 16'd0;
        end
        else if (advance)
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            bad_reg      <= bad_next;
            fcs_reg      <= fcs_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_map_reg  <= 32'd0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RX_MAP:  rx_map_reg  <= cfg_wdata;
                CFG_MAX_LEN: max_len_reg <= cfg_wdata[15:0];
                default:     ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/ppp_afr_out_reg.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_afr_out_reg
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ppp_afr_pkg::core_res_t       core_res,
    input  wire logic                         advance,
    output logic                              out_busy,
    ppp_afr_res_if.source                     res_out
);

    import ppp_afr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign load     = advance && core_res.valid;
    assign out_busy = valid_reg && !res_out.ready;

    assign res_out.valid        = valid_reg;
    assign res_out.is_end       = res_reg.is_end;
    assign res_out.data_byte    = res_reg.data_byte;
    assign res_out.frame_status = res_reg.frame_status;
    assign res_out.frame_length = res_reg.frame_length;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res_out.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= core_res.res;
    end

endmodule

`default_nettype wire

[design/ppp_async_frame_receive.sv]
// ----------------------------------------------------------------------------
// PPP async frame receive
// RFC 1662 async HDLC-like deframer with FCS-16 check.
// ----------------------------------------------------------------------------
// rx_in carries raw line bytes; res_out carries one result per delivered
// data byte (is_end 0) and one status result per closed frame (is_end 1,
// with frame_status and frame_length). Flags, escapes, mapped control
// bytes and bytes of a bad frame produce no result.
// A byte accepted into the input register is decoded by the core there,
// and its result is loaded into the output register, which drives res_out.
// Throughput: one byte per cycle while rx_in.ready is high; the single-pass
// decode and 8-step FCS update sit between the input and output registers.
// When res_out stalls, the output register holds its result; the input
// register still takes a byte and the core keeps consuming bytes that
// make no result. rx_in.ready drops only when a byte with a result waits
// behind a full output register.
// Reset clears frame state, FCS to 0xffff, receive map to 0 and the
// length limit to 1500. Configuration writes only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_async_frame_receive
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ppp_afr_rx_if.sink       rx_in,
    ppp_afr_res_if.source    res_out,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    import ppp_afr_pkg::*;

    `include "ppp_async_frame_receive_defines.svh"

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       advance;
    logic       out_busy;
    core_res_t  core_res;

    assign advance = s1_valid && (!core_res.valid || !out_busy);

    ppp_afr_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_in    (rx_in),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    ppp_afr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte),
        .advance   (advance),
        .core_res  (core_res)
    );

    ppp_afr_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .core_res (core_res),
        .advance  (advance),
        .out_busy (out_busy),
        .res_out  (res_out)
    );

    `PAFR_ASSERT_IMPLIES(a_end_fields, clk, rst_n,
        res_out.valid && res_out.is_end,
        res_out.data_byte == 8'd0 && res_out.frame_status != 2'd3,
        "end result with data byte or bad status code")

    `PAFR_ASSERT_IMPLIES(a_data_fields, clk, rst_n,
        res_out.valid && !res_out.is_end,
        res_out.frame_status == STATUS_GOOD && res_out.frame_length == 16'd0,
        "data result with status or length set")

    `PAFR_ASSERT_NEXT(a_no_drop, clk, rst_n,
        s1_valid && core_res.valid && out_busy,
        s1_valid && $stable(s1_byte),
        "pending byte lost while output stalled")

    `PAFR_ASSERT_IMPLIES(a_ready_path, clk, rst_n,
        !rx_in.ready,
        s1_valid && core_res.valid && out_busy,
        "input stalled without a blocked result")

endmodule

`default_nettype wire

[sim/ppp_afr_deframe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPP async deframer checker
// Watches the line byte and result channels and the register write port,
// predicts every deframed result and compares it field by field.
// ----------------------------------------------------------------------------

module ppp_afr_deframe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    ppp_afr_rx_if       rx,
    ppp_afr_res_if      res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          expected_left
);

    import ppp_afr_pkg::*;

    // mirrored registers
    logic [31:0] ctrl_drop_map;
    logic [15:0] len_limit;

    // deframer state
    logic        open_frame;
    logic        esc_seen;
    logic        frame_broken;
    logic [15:0] fcs_acc;
    logic [15:0] delivered;

    result_t     due_results[$];

    initial
    begin
        fail_count    = 0;
        expected_left = 0;
    end

    // reflected CRC-16, one data bit per step
    function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb  = crc[0] ^ d[k];
            crc = {1'b0, crc[15:1]};
            if (fb)
                crc = crc ^ FCS_POLY;
        end
        return crc;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0] v;
        r = '0;
        v = b;
        if (v == FLAG_BYTE)
        begin
            if (!open_frame)
                return 1'b0;
            if (esc_seen)
                frame_broken = 1'b1;
            r.is_end = 1'b1;
            if (frame_broken)
                r.frame_status = STATUS_BAD;
            else if (fcs_acc == FCS_GOOD)
                r.frame_status = STATUS_GOOD;
            else
                r.frame_status = STATUS_FCS_ERR;
            r.frame_length = delivered;
            open_frame = 1'b0;
            esc_seen   = 1'b0;
            return 1'b1;
        end
        if (!open_frame)
        begin
            open_frame   = 1'b1;
            esc_seen     = 1'b0;
            frame_broken = 1'b0;
            delivered    = '0;
            fcs_acc      = FCS_INIT;
        end
        if (frame_broken)
            return 1'b0;
        if (v == ESC_BYTE)
        begin
            esc_seen = 1'b1;
            return 1'b0;
        end
        // mapped control byte is dropped before unescape, escape stays armed
        if (v < 8'h20 && ctrl_drop_map[v[4:0]])
            return 1'b0;
        if (esc_seen)
        begin
            v        = v ^ ESC_XOR;
            esc_seen = 1'b0;
        end
        if (delivered >= len_limit)
        begin
            frame_broken = 1'b1;
            return 1'b0;
        end
        delivered   = delivered + 16'd1;
        fcs_acc     = fcs_next(fcs_acc, v);
        r.data_byte = v;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t pred;
        result_t want;
        if (!rst_n)
        begin
            ctrl_drop_map = '0;
            len_limit     = MAX_LEN_RESET;
            open_frame    = 1'b0;
            esc_seen      = 1'b0;
            frame_broken  = 1'b0;
            fcs_acc       = FCS_INIT;
            delivered     = '0;
            due_results.delete();
            expected_left = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RX_MAP:  ctrl_drop_map = cfg_wdata;
                    CFG_MAX_LEN: len_limit     = cfg_wdata[15:0];
                    default:     ;
                endcase
            end
            if (rx.valid && rx.ready)
            begin
                if (deframe_byte(rx.rx_byte, pred))
                    due_results.push_back(pred);
            end
            if (res.valid && res.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: is_end %0d data_byte %0h",
                           res.is_end, res.data_byte);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res.is_end !== want.is_end)
                    begin
                        $error("is_end expected %0d actual %0d", want.is_end, res.is_end);
                        fail_count++;
                    end
                    if (res.data_byte !== want.data_byte)
                    begin
                        $error("data_byte expected %0h actual %0h",
                               want.data_byte, res.data_byte);
                        fail_count++;
                    end
                    if (res.frame_status !== want.frame_status)
                    begin
                        $error("frame_status expected %0d actual %0d",
                               want.frame_status, res.frame_status);
                        fail_count++;
                    end
                    if (res.frame_length !== want.frame_length)
                    begin
                        $error("frame_length expected %0d actual %0d",
                               want.frame_length, res.frame_length);
                        fail_count++;
                    end
                end
            end
            expected_left = due_results.size();
        end
    end

endmodule

[sim/tb_ppp_async_frame_receive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPP async frame receive testbench
// Feeds line bytes of directed and random HDLC-like frames under several
// register settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_ppp_async_frame_receive;
    import ppp_afr_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SEGMENT_ITEMS = 130;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int          mismatch_count;
    int          results_due;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    int          stall_cycles;

    logic [7:0]  frame_bytes[$];
    logic [15:0] frame_fcs;

    ppp_afr_rx_if  rx_ch ();
    ppp_afr_res_if res_ch ();

    ppp_async_frame_receive dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_in     (rx_ch),
        .res_out   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ppp_afr_deframe_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .res           (res_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (mismatch_count),
        .expected_left (results_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result sink back-pressure
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("ppp_async_frame_receive test failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // hold the line until every predicted result is out, then let the pipe empty
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] map, input logic [31:0] len_word);
        wait_idle();
        write_reg(CFG_RX_MAP, map);
        write_reg(CFG_MAX_LEN, len_word);
        write_reg(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    // append with transparency: flag, escape and control chars go escaped
    task automatic add_octet(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE || b < 8'h20)
        begin
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(b ^ ESC_XOR);
        end
        else
            frame_bytes.push_back(b);
    endtask

    task automatic put_data(input logic [7:0] b);
        frame_fcs = fcs16_update(frame_fcs, b);
        add_octet(b);
    endtask

    task automatic close_good();
        logic [15:0] fv;
        fv = ~frame_fcs;
        add_octet(fv[7:0]);
        add_octet(fv[15:8]);
        frame_bytes.push_back(FLAG_BYTE);
    endtask

    function automatic logic [7:0] pick_octet();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return FLAG_BYTE;
        if (sel == 1)
            return ESC_BYTE;
        if (sel < 4)
            return 8'($urandom_range(31));
        return 8'($urandom_range(255));
    endfunction

    task automatic build_good(input int len);
        frame_fcs = FCS_INIT;
        repeat (len) put_data(pick_octet());
        close_good();
    endtask

    task automatic send_random_frame();
        int kind;
        int len;
        int idx;
        kind = $urandom_range(99);
        if ($urandom_range(39) == 0)
            wait_idle();
        if ($urandom_range(9) == 0)
            len = $urandom_range(13, 60);
        else
            len = $urandom_range(0, 12);
        if (kind < 55)
            build_good(len);
        else if (kind < 70)
        begin
            build_good(len);
            idx = $urandom_range(frame_bytes.size() - 2);
            frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
        end
        else if (kind < 80)
        begin
            // escape then flag aborts
            repeat (len) add_octet(pick_octet());
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(FLAG_BYTE);
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(FLAG_BYTE);
        end
        else
        begin
            // stray flags, then a frame opened by a raw control char
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(FLAG_BYTE);
            frame_bytes.push_back(8'($urandom_range(31)));
            frame_bytes.push_back(FLAG_BYTE);
        end
        send_frame_bytes();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        send_idle_pct = 11;
        recv_idle_pct = 76;
        items_sent    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: stray flag, good frame with escaped bytes, abort, FCS error
        frame_bytes.push_back(FLAG_BYTE);
        frame_fcs = FCS_INIT;
        put_data(8'h00);
        put_data(8'hff);
        put_data(FLAG_BYTE);
        close_good();
        frame_bytes.push_back(8'h41);
        frame_bytes.push_back(ESC_BYTE);
        frame_bytes.push_back(FLAG_BYTE);
        frame_bytes.push_back(8'h41);
        frame_bytes.push_back(FLAG_BYTE);
        send_frame_bytes();

        // all controls mapped, limit 2: empty frame, escape across a dropped
        // byte, overlong frame ending in escape-flag
        apply_settings(32'hffff_ffff, 32'd2);
        frame_bytes = '{8'h01, FLAG_BYTE, ESC_BYTE, 8'h01, 8'h5e, FLAG_BYTE,
                        8'h41, 8'h42, 8'h43, ESC_BYTE, FLAG_BYTE};
        send_frame_bytes();

        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 76;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: apply_settings($urandom, {16'($urandom), 16'hffff});
                1: apply_settings(32'h0, 32'd0);
                2: apply_settings(32'hffff_ffff, 32'd1);
                3: apply_settings($urandom, $urandom_range(8, 40));
                4: apply_settings(32'h0, {16'h0, MAX_LEN_RESET});
                default: apply_settings($urandom, $urandom_range(2, 20));
            endcase
            items_sent = 0;
            while (items_sent < SEGMENT_ITEMS)
                send_random_frame();
        end

        rx_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("ppp_async_frame_receive test passed");
        else
            $display("ppp_async_frame_receive test failed");
        $finish;
    end

endmodule
